/* rtl/core/rww_pkg.sv */
// Shared types and constants for the radial window weight pipeline.
`default_nettype none

package rww_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DIAMETER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KIND     = 3'd3;

  typedef enum logic [2:0] {
    KIND_RECT     = 3'd0,
    KIND_BARTLETT = 3'd1,
    KIND_TRIANGLE = 3'd2,
    KIND_HAMMING  = 3'd3,
    KIND_HANNING  = 3'd4
  } rww_kind_e;

  typedef struct packed {
    logic      valid;
    logic      in_radius;
    rww_kind_e kind;
  } rww_tag_t;

  typedef struct packed {
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
  } rww_in_t;

  typedef struct packed {
    logic [16:0] weight;
    logic        inside_res;
  } rww_out_t;

  // Q30 fixed point
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // Horner divisors of the cosine series with their reciprocals
  localparam int COS_STEPS = 6;
  localparam logic [7:0] COS_DIV [COS_STEPS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
  localparam int COS_SH [COS_STEPS] = '{39, 39, 38, 37, 36, 35};
  localparam logic [31:0] COS_RCP [COS_STEPS] = '{
    32'((64'd1 << 39) / 64'd182),
    32'((64'd1 << 39) / 64'd132),
    32'((64'd1 << 38) / 64'd90),
    32'((64'd1 << 37) / 64'd56),
    32'((64'd1 << 36) / 64'd30),
    32'((64'd1 << 35) / 64'd12)
  };

  // Hamming: (27*2^30 - 23c) / 50
  localparam logic signed [37:0] HAM_A   = 38'sd28991029248;
  localparam logic [35:0]        HAM_DIV = 36'd50;
  localparam int                 HAM_SH  = 37;
  localparam logic [31:0]        HAM_RCP = 32'((64'd1 << 37) / 64'd50);

  localparam int FRONT_STAGES = 3;
  localparam int SQ_STAGES    = 30;
  localparam int DIV_STAGES   = 31;
  localparam int COS_STAGES   = 3 + 3 * COS_STEPS;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY = FRONT_STAGES + SQ_STAGES + 1 + DIV_STAGES + COS_STAGES + BACK_STAGES;

endpackage

`default_nettype wire

/* rtl/core/rww_sqrt.sv */
// Pipelined integer square root of s * 2^32, one root bit per stage.
`default_nettype none

module rww_sqrt import rww_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rww_tag_t    tag_i,
  input  logic [27:0] s_i,
  output rww_tag_t    tag_o,
  output logic [29:0] root_o
);

  rww_tag_t    tag_r  [SQ_STAGES];
  logic [27:0] s_r    [SQ_STAGES];
  logic [30:0] rem_r  [SQ_STAGES];
  logic [29:0] root_r [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stg
    localparam int J = SQ_STAGES - 1 - i;
    rww_tag_t    tag_in;
    logic [27:0] s_in;
    logic [30:0] rem_in;
    logic [29:0] root_in;
    logic [1:0]  pair;
    logic [33:0] diff;
    logic [32:0] shifted;
    logic        ge;

    if (i == 0) begin : g_first
      assign tag_in  = tag_i;
      assign s_in    = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = tag_r[i-1];
      assign s_in    = s_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    if (J >= 16) begin : g_pair
      assign pair = s_in[2*(J-16)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign shifted = {rem_in, pair};
    assign diff    = {1'b0, shifted} - {2'b00, root_in, 2'b01};
    assign ge      = ~diff[33];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i] <= '0;
      end else begin
        tag_r[i] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      s_r[i]    <= s_in;
      rem_r[i]  <= ge ? diff[30:0] : shifted[30:0];
      root_r[i] <= {root_in[28:0], ge};
    end
  end

  assign tag_o  = tag_r[SQ_STAGES-1];
  assign root_o = root_r[SQ_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/rww_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rww_div import rww_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rww_tag_t    tag_i,
  input  logic [44:0] num_i,
  input  logic [14:0] den_i,
  output rww_tag_t    tag_o,
  output logic [30:0] quo_o
);

  rww_tag_t    tag_r [DIV_STAGES];
  logic [44:0] num_r [DIV_STAGES];
  logic [14:0] den_r [DIV_STAGES];
  logic [13:0] rem_r [DIV_STAGES];
  logic [30:0] quo_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stg
    localparam int B = DIV_STAGES - 1 - i;
    rww_tag_t    tag_in;
    logic [44:0] num_in;
    logic [14:0] den_in;
    logic [13:0] rem_in;
    logic [30:0] quo_in;
    logic [14:0] trial;
    logic [14:0] sub;
    logic        ge;

    if (i == 0) begin : g_first
      assign tag_in = tag_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = num_i[44:31];
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign trial = {rem_in, num_in[B]};
    assign ge    = (trial >= den_in);
    assign sub   = trial - den_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i] <= '0;
      end else begin
        tag_r[i] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[i] <= num_in;
      den_r[i] <= den_in;
      rem_r[i] <= ge ? sub[13:0] : trial[13:0];
      quo_r[i] <= {quo_in[29:0], ge};
    end
  end

  assign tag_o = tag_r[DIV_STAGES-1];
  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/rww_cos.sv */
// Pipelined cos(pi*p) for p in Q30, Taylor series in Horner form.
`default_nettype none

module rww_cos import rww_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rww_tag_t           tag_i,
  input  logic [30:0]        p_i,
  output rww_tag_t           tag_o,
  output logic [30:0]        p_o,
  output logic signed [31:0] c_o
);

  typedef struct packed {
    logic        neg;
    logic [30:0] p;
    logic [31:0] x;
  } cos_side_t;

  // fold into the first quarter turn
  logic [30:0] q_lim;
  logic        fold;
  logic [29:0] q_fold;
  logic [61:0] theta_prod;

  assign q_lim      = (p_i > ONE_Q30) ? '0 : p_i;
  assign fold       = (q_lim > HALF_Q30);
  assign q_fold     = fold ? 30'(ONE_Q30 - q_lim) : q_lim[29:0];
  assign theta_prod = 62'(q_fold) * 62'(PI_Q30);

  rww_tag_t    c0_tag_r;
  logic [30:0] c0_theta_r;
  logic        c0_neg_r;
  logic [30:0] c0_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_tag_r <= '0;
    end else begin
      c0_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    c0_theta_r <= theta_prod[60:30];
    c0_neg_r   <= fold;
    c0_p_r     <= p_i;
  end

  logic [61:0] x_prod;
  assign x_prod = 62'(c0_theta_r) * 62'(c0_theta_r);

  rww_tag_t  c1_tag_r;
  cos_side_t c1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_tag_r <= '0;
    end else begin
      c1_tag_r <= c0_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_side_r <= '{neg: c0_neg_r, p: c0_p_r, x: x_prod[61:30]};
  end

  rww_tag_t    sa_tag_r  [COS_STEPS];
  cos_side_t   sa_side_r [COS_STEPS];
  logic [31:0] sa_y_r    [COS_STEPS];
  rww_tag_t    sb_tag_r  [COS_STEPS];
  cos_side_t   sb_side_r [COS_STEPS];
  logic [31:0] sb_y_r    [COS_STEPS];
  logic [31:0] sb_q0_r   [COS_STEPS];
  rww_tag_t    sc_tag_r  [COS_STEPS];
  cos_side_t   sc_side_r [COS_STEPS];
  logic [30:0] sc_a_r    [COS_STEPS];

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_step
    rww_tag_t    tag_in;
    cos_side_t   side_in;
    logic [30:0] a_in;
    logic [62:0] xa;
    logic [63:0] yr;
    logic [31:0] q0k;
    logic [31:0] rem;
    logic [31:0] q;

    if (k == 0) begin : g_first
      assign tag_in  = c1_tag_r;
      assign side_in = c1_side_r;
      assign a_in    = ONE_Q30;
    end else begin : g_next
      assign tag_in  = sc_tag_r[k-1];
      assign side_in = sc_side_r[k-1];
      assign a_in    = sc_a_r[k-1];
    end

    // multiply by the running term
    assign xa = 63'(side_in.x) * 63'(a_in);
    // divide by the series constant through its reciprocal
    assign yr = 64'(sa_y_r[k]) * 64'(COS_RCP[k]);
    // correct the reciprocal estimate by at most one
    assign q0k = sb_q0_r[k] * 32'(COS_DIV[k]);
    assign rem = sb_y_r[k] - q0k;
    assign q   = (rem >= 32'(COS_DIV[k])) ? sb_q0_r[k] + 32'd1 : sb_q0_r[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sa_tag_r[k] <= '0;
        sb_tag_r[k] <= '0;
        sc_tag_r[k] <= '0;
      end else begin
        sa_tag_r[k] <= tag_in;
        sb_tag_r[k] <= sa_tag_r[k];
        sc_tag_r[k] <= sb_tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sa_side_r[k] <= side_in;
      sa_y_r[k]    <= xa[61:30];
      sb_side_r[k] <= sa_side_r[k];
      sb_y_r[k]    <= sa_y_r[k];
      sb_q0_r[k]   <= 32'(yr >> COS_SH[k]);
      sc_side_r[k] <= sb_side_r[k];
      sc_a_r[k]    <= 31'(32'(ONE_Q30) - q);
    end
  end

  logic [62:0]        fin_prod;
  logic signed [31:0] c_pos;
  cos_side_t          last_side;

  assign last_side = sc_side_r[COS_STEPS-1];
  assign fin_prod  = 63'(last_side.x) * 63'(sc_a_r[COS_STEPS-1]);
  assign c_pos     = $signed(32'(ONE_Q30)) - $signed(fin_prod[62:31]);

  rww_tag_t           cf_tag_r;
  logic [30:0]        cf_p_r;
  logic signed [31:0] cf_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_tag_r <= '0;
    end else begin
      cf_tag_r <= sc_tag_r[COS_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    cf_p_r <= last_side.p;
    cf_c_r <= last_side.neg ? -c_pos : c_pos;
  end

  assign tag_o = cf_tag_r;
  assign p_o   = cf_p_r;
  assign c_o   = cf_c_r;

endmodule

`default_nettype wire

/* rtl/core/radial_window_weight_top.sv */
// Top level of the radial window weight pipeline.
//
//  channel | ports                              | transfer when
//  --------+------------------------------------+----------------------------
//  input   | start, busy, in_data               | start & !busy at clk edge
//  result  | out_strobe, out_data               | out_strobe at clk edge
//  config  | cfg_valid, cfg_ready, cfg_index,   | cfg_valid & cfg_ready
//          | cfg_data                           |
//
// One pixel enters per cycle while busy is low; each result passes through
// the pipeline stages after its transfer in: 3 front stages, 30 root
// stages, 1 stage forming n, 31 divider stages, 21 cosine stages and
// 3 output stages. rst_n is synchronous; it clears the valid bits of every
// stage, and busy stays high in the cycle after reset. The result side
// cannot stall, so the pipeline never holds and nothing backs up.
`default_nettype none

module radial_window_weight_top import rww_pkg::*; #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rww_in_t               in_data,
  output logic                  out_strobe,
  output rww_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W_SHIFT = 30 - FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready, writes take effect in the next cycle.
  // ---------------------------------------------------------------------------
  logic [12:0] img_w_r;
  logic [12:0] img_h_r;
  logic [13:0] diam_r;
  logic [2:0]  kind_r;
  logic        busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 13'd256;
      img_h_r <= 13'd256;
      diam_r  <= 14'd64;
      kind_r  <= 3'd0;
      busy_r  <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:     img_w_r <= cfg_data[12:0];
          REG_IMAGE_HEIGHT:    img_h_r <= cfg_data[12:0];
          REG_WINDOW_DIAMETER: diam_r  <= cfg_data[13:0];
          REG_WINDOW_KIND:     kind_r  <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // Derived constants: clamp sizes, floor the diameter at 2, precompute
  // (D-1), (D+1) and (D-1)^2. The clamped sizes feed the first stage
  // directly, so a pixel right after a size write sees the new size; the
  // diameter terms are registered since they are first used two stages in.
  logic [12:0] wc_clamp, hc_clamp;
  logic [13:0] dc;
  logic [13:0] dm1_nxt;
  logic [14:0] dp1_nxt;
  logic [27:0] dm1sq_nxt;
  logic [13:0] dm1_r;
  logic [14:0] dp1_r;
  logic [27:0] dm1sq_r;

  assign wc_clamp  = (32'(img_w_r) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : img_w_r;
  assign hc_clamp  = (32'(img_h_r) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : img_h_r;
  assign dc        = (diam_r < 14'd2) ? 14'd2 : diam_r;
  assign dm1_nxt   = dc - 14'd1;
  assign dp1_nxt   = {1'b0, dc} + 15'd1;
  assign dm1sq_nxt = 28'(dm1_nxt) * 28'(dm1_nxt);

  always_ff @(posedge clk) begin
    dm1_r   <= dm1_nxt;
    dp1_r   <= dp1_nxt;
    dm1sq_r <= dm1sq_nxt;
  end

  // ---------------------------------------------------------------------------
  // Front: doubled distances, squares, radius test.
  // ---------------------------------------------------------------------------
  rww_tag_t           st1_tag_nxt;
  logic signed [15:0] dx, dy;
  logic [13:0]        ax, ay;

  assign st1_tag_nxt.valid     = start && !busy;
  assign st1_tag_nxt.in_radius = 1'b0;
  assign st1_tag_nxt.kind      = rww_kind_e'(kind_r);

  assign dx = $signed({3'b000, wc_clamp}) + 16'sd1 - $signed({2'b00, in_data.pixel_x, 1'b0});
  assign dy = $signed({3'b000, hc_clamp}) + 16'sd1 - $signed({2'b00, in_data.pixel_y, 1'b0});
  assign ax = dx[15] ? 14'(-dx) : dx[13:0];
  assign ay = dy[15] ? 14'(-dy) : dy[13:0];

  rww_tag_t    st1_tag_r, st2_tag_r, st3_tag_r;
  logic [13:0] st1_ax_r, st1_ay_r;
  logic [27:0] st2_sqx_r, st2_sqy_r;
  logic [27:0] st3_s_r;
  logic [28:0] s_sum;
  logic        rad_hit;
  rww_tag_t    st3_tag_nxt;

  assign s_sum   = {1'b0, st2_sqx_r} + {1'b0, st2_sqy_r};
  assign rad_hit = (s_sum <= {1'b0, dm1sq_r});

  always_comb begin
    st3_tag_nxt           = st2_tag_r;
    st3_tag_nxt.in_radius = rad_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_tag_r <= '0;
      st2_tag_r <= '0;
      st3_tag_r <= '0;
    end else begin
      st1_tag_r <= st1_tag_nxt;
      st2_tag_r <= st1_tag_r;
      st3_tag_r <= st3_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st1_ax_r  <= ax;
    st1_ay_r  <= ay;
    st2_sqx_r <= 28'(st1_ax_r) * 28'(st1_ax_r);
    st2_sqy_r <= 28'(st1_ay_r) * 28'(st1_ay_r);
    // drop the sum of an outside pixel; its weight is forced to zero
    st3_s_r   <= rad_hit ? s_sum[27:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // 2*rad in Q16
  // ---------------------------------------------------------------------------
  rww_tag_t    sq_tag;
  logic [29:0] sq_root;

  rww_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (st3_tag_r),
    .s_i    (st3_s_r),
    .tag_o  (sq_tag),
    .root_o (sq_root)
  );

  // 2n in Q16, then pick the Bartlett or triangle division.
  logic [29:0] m_val;
  logic [30:0] m_tri;
  logic        use_tri;
  rww_tag_t    mn_tag_r;
  logic [44:0] mn_num_r;
  logic [14:0] mn_den_r;

  assign m_val   = {dm1_r, 16'h0000} - sq_root;
  assign m_tri   = {1'b0, m_val} + 31'h0002_0000;
  assign use_tri = (sq_tag.kind == KIND_TRIANGLE) || (sq_tag.kind == KIND_HANNING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mn_tag_r <= '0;
    end else begin
      mn_tag_r <= sq_tag;
    end
  end

  always_ff @(posedge clk) begin
    mn_num_r <= use_tri ? {m_tri, 14'h0000} : {1'b0, m_val, 14'h0000};
    mn_den_r <= use_tri ? dp1_r : {1'b0, dm1_r};
  end

  rww_tag_t    dv_tag;
  logic [30:0] dv_quo;

  rww_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (mn_tag_r),
    .num_i (mn_num_r),
    .den_i (mn_den_r),
    .tag_o (dv_tag),
    .quo_o (dv_quo)
  );

  rww_tag_t           cs_tag;
  logic [30:0]        cs_p;
  logic signed [31:0] cs_c;

  rww_cos u_cos (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (dv_tag),
    .p_i   (dv_quo),
    .tag_o (cs_tag),
    .p_o   (cs_p),
    .c_o   (cs_c)
  );

  // ---------------------------------------------------------------------------
  // Back end: Hamming / Hanning blend, select, round to FRAC_BITS.
  // ---------------------------------------------------------------------------
  logic signed [37:0] ham_num;
  logic signed [32:0] hann_diff;

  assign ham_num   = HAM_A - 38'sd23 * 38'(cs_c);
  assign hann_diff = 33'sh0_4000_0000 - 33'(cs_c);

  rww_tag_t    f1_tag_r, f2_tag_r;
  logic [35:0] f1_hn_r, f2_hn_r;
  logic [30:0] f1_hann_r, f2_hann_r;
  logic [30:0] f1_p_r, f2_p_r;
  logic [30:0] f2_q0_r;
  logic [67:0] ham_prod;

  assign ham_prod = 68'(f1_hn_r) * 68'(HAM_RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_tag_r <= '0;
      f2_tag_r <= '0;
    end else begin
      f1_tag_r <= cs_tag;
      f2_tag_r <= f1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_hn_r   <= ham_num[35:0];
    f1_hann_r <= hann_diff[31:1];
    f1_p_r    <= cs_p;
    f2_hn_r   <= f1_hn_r;
    f2_hann_r <= f1_hann_r;
    f2_p_r    <= f1_p_r;
    f2_q0_r   <= ham_prod[HAM_SH +: 31];
  end

  logic [35:0] ham_rem;
  logic [30:0] ham_q;
  logic [30:0] wq;
  logic [31:0] wq_rnd;
  rww_out_t    out_nxt;

  assign ham_rem = f2_hn_r - 36'(f2_q0_r) * HAM_DIV;
  assign ham_q   = (ham_rem >= HAM_DIV) ? f2_q0_r + 31'd1 : f2_q0_r;

  always_comb begin
    case (f2_tag_r.kind)
      KIND_RECT:     wq = ONE_Q30;
      KIND_BARTLETT: wq = f2_p_r;
      KIND_TRIANGLE: wq = f2_p_r;
      KIND_HAMMING:  wq = ham_q;
      KIND_HANNING:  wq = f2_hann_r;
      default:       wq = '0;
    endcase
  end

  assign wq_rnd = 32'(wq) + (32'd1 << (W_SHIFT - 1));

  always_comb begin
    out_nxt.inside_res = f2_tag_r.in_radius;
    out_nxt.weight     = f2_tag_r.in_radius ? 17'(wq_rnd >> W_SHIFT) : '0;
  end

  logic     out_strobe_r;
  rww_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= f2_tag_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Every transfer in comes out as a result strobe at the end of the pipeline.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("result strobe missing at fixed latency");

  // A pixel outside the radius carries no weight.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.inside_res) |-> (out_data.weight == '0))
    else $error("nonzero weight outside window radius");

  // Nothing leaves the pipeline in the cycle right after reset.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire
